>>> rtl/rcp_pkg.sv
// Package for the RTCP compound parser: record kinds, packet types, record struct.
// No dependencies.
package rcp_pkg;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_SSRC    = 3'd1;
	localparam logic [2:0] KIND_SINFO   = 3'd2;
	localparam logic [2:0] KIND_REPORT  = 3'd3;
	localparam logic [2:0] KIND_MEDIA   = 3'd4;
	localparam logic [2:0] KIND_PAYLOAD = 3'd5;
	localparam logic [2:0] KIND_PKTEND  = 3'd6;
	localparam logic [2:0] KIND_BUFEND  = 3'd7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_TRUNC     = 2'd2;

	localparam logic [7:0] T_SR    = 8'd200;
	localparam logic [7:0] T_RR    = 8'd201;
	localparam logic [7:0] T_RTPFB = 8'd205;
	localparam logic [7:0] T_PSFB  = 8'd206;

	// Packed record: 118 bits.
	typedef struct packed {
		logic        last;
		logic [7:0]  pad_length;
		logic [1:0]  status;
		logic [15:0] length_words;
		logic [7:0]  packet_kind;
		logic [4:0]  rpt_count;
		logic        padding_flag;
		logic [1:0]  version;
		logic [63:0] field_value;
		logic [4:0]  block_index;
		logic [2:0]  field_index;
		logic [2:0]  record_kind;
	} rec_t;

	localparam int QUEUE_DEPTH = 4;

	// Up to three records per byte, with a count.
	typedef struct packed {
		logic [1:0] count;
		rec_t       r2;
		rec_t       r1;
		rec_t       r0;
	} group_t;

endpackage

>>> rtl/rcp_front.sv
// Front end: accepts bytes, tracks packet offsets and builds the record group per byte.
// Depends on rcp_pkg.
module rcp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output rcp_pkg::group_t      grp,
	output logic                 grp_valid
);

	logic [17:0] offset_q, total_q, pstart_q;
	logic [7:0]  hkind_q;
	logic        pad_q, skip_q;
	logic [55:0] acc_q;
	// Report block number and the byte position inside the block, counted as bytes arrive.
	logic [4:0]  blk_q, wpos_q;

	logic [63:0] acc;
	assign acc = {acc_q, in_byte};

	function automatic logic known(input logic [7:0] k);
		return (k >= rcp_pkg::T_SR) && (k <= rcp_pkg::T_PSFB);
	endfunction

	function automatic rcp_pkg::rec_t mk(input logic [2:0] kind, input logic [2:0] fi,
	                                     input logic [4:0] bi, input logic [63:0] v);
		rcp_pkg::rec_t r;
		r = '0;
		r.record_kind = kind;
		r.field_index = fi;
		r.block_index = bi;
		r.field_value = v;
		return r;
	endfunction

	rcp_pkg::rec_t rs [3];
	logic [1:0] n;
	logic [17:0] n_off, n_total, n_pstart, base;
	logic [7:0]  n_kind, b0;
	logic        n_pad, n_skip, shortp, have_st;
	logic [1:0]  st;
	logic [7:0]  padl;
	logic [17:0] plen;
	logic        fe, in_rep;
	rcp_pkg::rec_t fr;
	logic [63:0] w32;

	always_comb begin
		rs[0] = '0; rs[1] = '0; rs[2] = '0;
		n = 2'd0;
		n_off = offset_q; n_total = total_q; n_pstart = pstart_q;
		n_kind = hkind_q; n_pad = pad_q; n_skip = skip_q;
		shortp = 1'b0; have_st = 1'b0; st = rcp_pkg::ST_OK; padl = 8'd0;
		fe = 1'b0; fr = '0; plen = '0; base = '0; in_rep = 1'b0;
		b0 = acc[31:24];
		w32 = {32'd0, acc[31:0]};
		if (skip_q) begin
		end else if (offset_q < 18'd3) begin
			n_off = offset_q + 18'd1;
		end else begin
			if (offset_q == 18'd3) begin
				n_kind = acc[23:16];
				n_pad = b0[5];
				n_total = {acc[15:0], 2'b11};
				if (n_kind == rcp_pkg::T_SR)
					n_pstart = 18'd28 + 18'(b0[4:0]) * 18'd24;
				else if (n_kind == rcp_pkg::T_RR)
					n_pstart = 18'd8 + 18'(b0[4:0]) * 18'd24;
				else if (n_kind == rcp_pkg::T_RTPFB || n_kind == rcp_pkg::T_PSFB)
					n_pstart = 18'd12;
				else
					n_pstart = 18'd4;
				rs[0] = '0;
				rs[0].record_kind = rcp_pkg::KIND_HEADER;
				rs[0].version = b0[7:6];
				rs[0].padding_flag = b0[5];
				rs[0].rpt_count = b0[4:0];
				rs[0].packet_kind = n_kind;
				rs[0].length_words = acc[15:0];
				n = 2'd1;
				shortp = known(n_kind) && (19'(n_pstart) > 19'(n_total) + 19'd1);
			end else begin
				if (hkind_q == rcp_pkg::T_SR || hkind_q == rcp_pkg::T_RR) begin
					base = (hkind_q == rcp_pkg::T_SR) ? 18'd28 : 18'd8;
					if (offset_q == 18'd7) begin
						fe = 1'b1; fr = mk(rcp_pkg::KIND_SSRC, 3'd0, 5'd0, w32);
					end else if (hkind_q == rcp_pkg::T_SR && offset_q < 18'd28) begin
						fe = 1'b1;
						case (offset_q[4:0])
							5'd15: fr = mk(rcp_pkg::KIND_SINFO, 3'd0, 5'd0, acc);
							5'd19: fr = mk(rcp_pkg::KIND_SINFO, 3'd1, 5'd0, w32);
							5'd23: fr = mk(rcp_pkg::KIND_SINFO, 3'd2, 5'd0, w32);
							5'd27: fr = mk(rcp_pkg::KIND_SINFO, 3'd3, 5'd0, w32);
							default: fe = 1'b0;
						endcase
					end else if (offset_q >= base && offset_q < pstart_q) begin
						in_rep = 1'b1;
						fe = 1'b1;
						case (wpos_q)
							5'd3:  fr = mk(rcp_pkg::KIND_REPORT, 3'd0, blk_q, w32);
							5'd4:  fr = mk(rcp_pkg::KIND_REPORT, 3'd1, blk_q,
							               {56'd0, in_byte});
							5'd7:  fr = mk(rcp_pkg::KIND_REPORT, 3'd2, blk_q,
							               {40'd0, acc[23:0]});
							5'd11: fr = mk(rcp_pkg::KIND_REPORT, 3'd3, blk_q, w32);
							5'd15: fr = mk(rcp_pkg::KIND_REPORT, 3'd4, blk_q, w32);
							5'd19: fr = mk(rcp_pkg::KIND_REPORT, 3'd5, blk_q, w32);
							5'd23: fr = mk(rcp_pkg::KIND_REPORT, 3'd6, blk_q, w32);
							default: fe = 1'b0;
						endcase
					end else if (offset_q >= pstart_q) begin
						fe = 1'b1;
						fr = mk(rcp_pkg::KIND_PAYLOAD, 3'd0, 5'd0, {56'd0, in_byte});
					end
				end else if (hkind_q == rcp_pkg::T_RTPFB || hkind_q == rcp_pkg::T_PSFB) begin
					if (offset_q == 18'd11) begin
						fe = 1'b1; fr = mk(rcp_pkg::KIND_MEDIA, 3'd0, 5'd0, w32);
					end else if (offset_q >= 18'd12) begin
						fe = 1'b1;
						fr = mk(rcp_pkg::KIND_PAYLOAD, 3'd0, 5'd0, {56'd0, in_byte});
					end
				end else if (known(hkind_q)) begin
					fe = 1'b1;
					fr = mk(rcp_pkg::KIND_PAYLOAD, 3'd0, 5'd0, {56'd0, in_byte});
				end
				if (fe) begin
					rs[0] = fr; n = 2'd1;
				end
			end
			if (shortp) begin
				have_st = 1'b1;
				st = (in_last && n_total > 18'd3) ? rcp_pkg::ST_TRUNC : rcp_pkg::ST_MALFORMED;
			end else if (offset_q == n_total) begin
				have_st = 1'b1;
				st = rcp_pkg::ST_OK;
				if (known(n_kind) && n_pad) begin
					plen = n_total + 18'd1 - n_pstart;
					if (plen != 18'd0) begin
						if (in_byte == 8'd0 || 18'(in_byte) > plen)
							st = rcp_pkg::ST_MALFORMED;
						else
							padl = in_byte;
					end
				end
			end else if (in_last) begin
				have_st = 1'b1;
				st = rcp_pkg::ST_TRUNC;
			end
			if (have_st) begin
				rs[n] = '0;
				rs[n].record_kind = rcp_pkg::KIND_PKTEND;
				rs[n].status = st;
				rs[n].pad_length = (st == rcp_pkg::ST_OK) ? padl : 8'd0;
				n = n + 2'd1;
				n_off = '0;
				if (st == rcp_pkg::ST_MALFORMED)
					n_skip = 1'b1;
			end else begin
				n_off = offset_q + 18'd1;
			end
		end
		if (in_last) begin
			rs[n] = '0;
			rs[n].record_kind = rcp_pkg::KIND_BUFEND;
			n = n + 2'd1;
			n_off = '0; n_total = '0; n_kind = '0; n_pad = 1'b0;
			n_pstart = '0; n_skip = 1'b0;
		end
		if (n != 2'd0)
			rs[n - 2'd1].last = 1'b1;
	end

	assign grp.count = n;
	assign grp.r0 = rs[0];
	assign grp.r1 = rs[1];
	assign grp.r2 = rs[2];
	assign grp_valid = in_valid && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0; total_q <= '0; pstart_q <= '0; hkind_q <= '0;
			pad_q <= 1'b0; skip_q <= 1'b0; acc_q <= '0; blk_q <= '0; wpos_q <= '0;
		end else if (in_valid) begin
			offset_q <= n_off; total_q <= n_total; pstart_q <= n_pstart;
			hkind_q <= n_kind; pad_q <= n_pad; skip_q <= n_skip;
			acc_q <= acc[55:0];
			if (!in_rep) begin
				blk_q <= '0; wpos_q <= '0;
			end else if (wpos_q == 5'd23) begin
				blk_q <= blk_q + 5'd1; wpos_q <= '0;
			end else begin
				wpos_q <= wpos_q + 5'd1;
			end
		end
	end

endmodule

>>> rtl/rcp_queue.sv
// Short queue of record groups between front end and back end.
// Depends on rcp_pkg.
module rcp_queue #(
	parameter int DEPTH = rcp_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  rcp_pkg::group_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output rcp_pkg::group_t rd_data,
	output logic            empty
);

	localparam int AW = $clog2(DEPTH);
	rcp_pkg::group_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en && !full)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en && !empty)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) full |=> !(cnt_q == '0))
		else $error("queue emptied from full in one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !full && !rd_en) |=> !empty)
		else $error("write lost");

endmodule

>>> rtl/rcp_back.sv
// Back end: serializes each record group onto the output stream through a register.
// Depends on rcp_pkg.
module rcp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rcp_pkg::group_t grp,
	input  logic            grp_valid,
	output logic            grp_pop,
	output rcp_pkg::rec_t   rec,
	output logic            rec_valid,
	input  logic            rec_ready
);

	logic [1:0] idx_q;
	logic       take;
	logic       rec_valid_q;
	rcp_pkg::rec_t sel, rec_q;

	always_comb begin
		case (idx_q)
			2'd0: sel = grp.r0;
			2'd1: sel = grp.r1;
			2'd2: sel = grp.r2;
			default: sel = grp.r0;
		endcase
	end

	assign rec = rec_q;
	assign rec_valid = rec_valid_q;
	assign take = grp_valid && (!rec_valid_q || rec_ready);
	assign grp_pop = take && (idx_q + 2'd1 == grp.count);

	always_ff @(posedge clk) begin
		if (take)
			rec_q <= sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; rec_valid_q <= 1'b0;
		end else begin
			if (take) begin
				rec_valid_q <= 1'b1;
				idx_q <= grp_pop ? 2'd0 : idx_q + 2'd1;
			end else if (rec_ready) begin
				rec_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) grp_valid |-> idx_q < grp.count)
		else $error("record index past group");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid_q && !rec_ready) |=> $stable(rec_q))
		else $error("stalled record changed");
	assert property (@(posedge clk) disable iff (!arst_n) !grp_valid |-> idx_q == 2'd0)
		else $error("index left dangling");

endmodule

>>> rtl/rtcp_compound_parser.sv
// Top level of the RTCP compound parser: front end, group queue, back end.
// Depends on rcp_pkg, rcp_front, rcp_queue, rcp_back.
// A byte's records pass through the group queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte yields up
// to three records; the single output register emits one per cycle on m_tready.
// Reset: arst_n clears all parse state and the queue at once; no clearing pass.
module rtcp_compound_parser #(
	parameter int QUEUE_DEPTH = rcp_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tlast,   // last_of_buffer
	output logic         m_tvalid,
	input  logic         m_tready,
	// field_index[2:0], block_index[7:3], field_value[71:8], version[73:72],
	// report_count[78:74], packet_kind[86:79], length_words[102:87],
	// status[104:103], pad_length[112:105], zero fill to 120
	output logic [119:0] m_tdata,
	output logic [3:0]   m_tuser,   // record_kind[2:0], padding_flag[3]
	output logic         m_tlast    // last
);

	rcp_pkg::group_t fgrp, qgrp;
	logic fvalid, qfull, qempty, pop;
	rcp_pkg::rec_t r;

	// Bytes with no records skip the queue, but every byte waits while it is full.
	assign s_tready = !qfull;

	rcp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid && s_tready),
		.in_byte(s_tdata), .in_last(s_tlast), .grp(fgrp), .grp_valid(fvalid)
	);

	rcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(fvalid), .wr_data(fgrp), .full(qfull),
		.rd_en(pop), .rd_data(qgrp), .empty(qempty)
	);

	rcp_back u_back (
		.clk(clk), .arst_n(arst_n), .grp(qgrp), .grp_valid(!qempty), .grp_pop(pop),
		.rec(r), .rec_valid(m_tvalid), .rec_ready(m_tready)
	);

	assign m_tdata = {7'd0, r.pad_length, r.status, r.length_words, r.packet_kind,
	                  r.rpt_count, r.version, r.field_value, r.block_index,
	                  r.field_index};
	assign m_tuser = {r.padding_flag, r.record_kind};
	assign m_tlast = r.last;

endmodule

>>> sim/rtcp_compound_parser_tb.sv
// Self-checking testbench for rtcp_compound_parser: feeds compound RTCP buffers byte by byte
// and checks every output record against a behavioral predictor kept inside this module.
// Depends on rcp_pkg and the rtcp_compound_parser RTL.
module rtcp_compound_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Packet types that the package does not name.
	localparam logic [7:0] T_BYE  = 8'd203;
	localparam logic [7:0] T_APP  = 8'd204;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic [3:0]   m_tuser;
	logic         m_tlast;

	rtcp_compound_parser DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	// Expected records, oldest first.
	rcp_pkg::rec_t pending_records[$];
	int   error_count = 0;
	int   cycle_count = 0;
	bit   no_idle = 1'b0;     // set for the last part of the run
	int   hold_cycles = 0;    // long receiver hold-off requested by a test
	int   rx_idle_left = 0;

	// Parser state as the predictor tracks it.
	int          pkt_offset;
	int          pkt_last_offset;
	logic [7:0]  pkt_type;
	logic        pkt_padded;
	logic [4:0]  pkt_reports;
	logic [63:0] byte_history;
	int          pkt_payload_start;
	bit          skipping;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rtcp_compound_parser_tb: errors");
			$finish;
		end
	end

	// Receiver: random ready bursts, plus a long hold-off when a test asks for one.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else if (no_idle) begin
			m_tready <= 1'b1;
		end else if (rx_idle_left > 0) begin
			m_tready <= 1'b0;
			rx_idle_left--;
		end else if ($urandom_range(0, 11) == 0) begin
			m_tready <= 1'b0;
			rx_idle_left = $urandom_range(0, 15);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker. Sampling on the falling edge sees settled values for the next rising edge.
	always @(negedge clk) begin
		rcp_pkg::rec_t got;
		rcp_pkg::rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '0;
			got.record_kind  = m_tuser[2:0];
			got.padding_flag = m_tuser[3];
			got.field_index  = m_tdata[2:0];
			got.block_index  = m_tdata[7:3];
			got.field_value  = m_tdata[71:8];
			got.version      = m_tdata[73:72];
			got.rpt_count    = m_tdata[78:74];
			got.packet_kind  = m_tdata[86:79];
			got.length_words = m_tdata[102:87];
			got.status       = m_tdata[104:103];
			got.pad_length   = m_tdata[112:105];
			got.last         = m_tlast;
			if (pending_records.size() == 0) begin
				$display("%0t: unexpected record, expected none, actual %p", $realtime, got);
				error_count++;
			end else begin
				want = pending_records.pop_front();
				if (got !== want) begin
					$display("%0t: record mismatch, expected %p, actual %p",
						$realtime, want, got);
					error_count++;
				end
			end
		end
	end

	function automatic rcp_pkg::rec_t make_record(logic [2:0] kind, logic [2:0] fidx,
			logic [4:0] bidx, logic [63:0] val);
		rcp_pkg::rec_t r;
		r = '0;
		r.record_kind = kind;
		r.field_index = fidx;
		r.block_index = bidx;
		r.field_value = val;
		return r;
	endfunction

	// Appends one plain record to a list.
	function automatic void emit_record(ref rcp_pkg::rec_t q[$], input logic [2:0] kind,
			input logic [2:0] fidx, input logic [4:0] bidx, input logic [63:0] val);
		q.insert(q.size(), make_record(kind, fidx, bidx, val));
	endfunction

	function automatic bit is_known_type(logic [7:0] t);
		return t >= rcp_pkg::T_SR && t <= rcp_pkg::T_PSFB;
	endfunction

	task automatic reset_parse();
		pkt_offset = 0;
		pkt_last_offset = 0;
		pkt_type = '0;
		pkt_padded = 1'b0;
		pkt_reports = '0;
		pkt_payload_start = 0;
		skipping = 1'b0;
	endtask

	// Works out the records that one accepted byte causes and queues them.
	task automatic predict_byte(input logic [7:0] b, input logic end_of_buf);
		rcp_pkg::rec_t recs[$];
		rcp_pkg::rec_t r;
		int st;
		logic [7:0] pad_len;
		int o;
		bit short_pkt;
		int plen;
		int base;
		int rel;
		logic [4:0] blk;
		logic [31:0] hdr;
		logic [31:0] w32;
		st = -1;
		pad_len = '0;
		short_pkt = 1'b0;
		byte_history = {byte_history[55:0], b};
		w32 = byte_history[31:0];
		if (skipping) begin
			// After a malformed packet nothing but the buffer end counts.
		end else if (pkt_offset < 3) begin
			pkt_offset++;
		end else begin
			o = pkt_offset;
			if (o == 3) begin
				hdr = byte_history[31:0];
				pkt_type = hdr[23:16];
				pkt_padded = hdr[29];
				pkt_reports = hdr[28:24];
				pkt_last_offset = int'(hdr[15:0]) * 4 + 3;
				if (pkt_type == rcp_pkg::T_SR)
					pkt_payload_start = 28 + 24 * int'(pkt_reports);
				else if (pkt_type == rcp_pkg::T_RR)
					pkt_payload_start = 8 + 24 * int'(pkt_reports);
				else if (pkt_type == rcp_pkg::T_RTPFB || pkt_type == rcp_pkg::T_PSFB)
					pkt_payload_start = 12;
				else
					pkt_payload_start = 4;
				r = make_record(rcp_pkg::KIND_HEADER, 3'd0, 5'd0, 64'd0);
				r.version = hdr[31:30];
				r.padding_flag = pkt_padded;
				r.rpt_count = pkt_reports;
				r.packet_kind = pkt_type;
				r.length_words = hdr[15:0];
				recs.insert(recs.size(), r);
				short_pkt = is_known_type(pkt_type) && pkt_payload_start > pkt_last_offset + 1;
			end else if (pkt_type == rcp_pkg::T_SR || pkt_type == rcp_pkg::T_RR) begin
				base = (pkt_type == rcp_pkg::T_SR) ? 28 : 8;
				if (o == 7) begin
					emit_record(recs, rcp_pkg::KIND_SSRC, 3'd0, 5'd0, 64'(w32));
				end else if (pkt_type == rcp_pkg::T_SR && o < 28) begin
					case (o)
						15: emit_record(recs, rcp_pkg::KIND_SINFO, 3'd0, 5'd0, byte_history);
						19: emit_record(recs, rcp_pkg::KIND_SINFO, 3'd1, 5'd0, 64'(w32));
						23: emit_record(recs, rcp_pkg::KIND_SINFO, 3'd2, 5'd0, 64'(w32));
						27: emit_record(recs, rcp_pkg::KIND_SINFO, 3'd3, 5'd0, 64'(w32));
						default: ;
					endcase
				end else if (o >= base && o < pkt_payload_start) begin
					rel = o - base;
					blk = 5'(rel / 24);
					case (rel % 24)
						3:  emit_record(recs, rcp_pkg::KIND_REPORT, 3'd0, blk, 64'(w32));
						4:  emit_record(recs, rcp_pkg::KIND_REPORT, 3'd1, blk, 64'(b));
						7:  emit_record(recs, rcp_pkg::KIND_REPORT, 3'd2, blk, 64'(w32[23:0]));
						11: emit_record(recs, rcp_pkg::KIND_REPORT, 3'd3, blk, 64'(w32));
						15: emit_record(recs, rcp_pkg::KIND_REPORT, 3'd4, blk, 64'(w32));
						19: emit_record(recs, rcp_pkg::KIND_REPORT, 3'd5, blk, 64'(w32));
						23: emit_record(recs, rcp_pkg::KIND_REPORT, 3'd6, blk, 64'(w32));
						default: ;
					endcase
				end else if (o >= pkt_payload_start) begin
					emit_record(recs, rcp_pkg::KIND_PAYLOAD, 3'd0, 5'd0, 64'(b));
				end
			end else if (pkt_type == rcp_pkg::T_RTPFB || pkt_type == rcp_pkg::T_PSFB) begin
				// The feedback sender SSRC is consumed silently.
				if (o == 11)
					emit_record(recs, rcp_pkg::KIND_MEDIA, 3'd0, 5'd0, 64'(w32));
				else if (o >= 12)
					emit_record(recs, rcp_pkg::KIND_PAYLOAD, 3'd0, 5'd0, 64'(b));
			end else if (is_known_type(pkt_type)) begin
				emit_record(recs, rcp_pkg::KIND_PAYLOAD, 3'd0, 5'd0, 64'(b));
			end

			if (short_pkt) begin
				st = (end_of_buf && pkt_last_offset > 3) ? rcp_pkg::ST_TRUNC
					: rcp_pkg::ST_MALFORMED;
			end else if (o == pkt_last_offset) begin
				st = rcp_pkg::ST_OK;
				// Padding only matters for known types with a non-empty payload.
				if (is_known_type(pkt_type) && pkt_padded) begin
					plen = pkt_last_offset + 1 - pkt_payload_start;
					if (plen > 0) begin
						if (b == 0 || int'(b) > plen)
							st = rcp_pkg::ST_MALFORMED;
						else
							pad_len = b;
					end
				end
			end else if (end_of_buf) begin
				st = rcp_pkg::ST_TRUNC;
			end

			if (st >= 0) begin
				r = make_record(rcp_pkg::KIND_PKTEND, 3'd0, 5'd0, 64'd0);
				r.status = 2'(st);
				r.pad_length = (st == rcp_pkg::ST_OK) ? pad_len : 8'd0;
				recs.insert(recs.size(), r);
				pkt_offset = 0;
				if (st == rcp_pkg::ST_MALFORMED)
					skipping = 1'b1;
			end else begin
				pkt_offset = o + 1;
			end
		end

		if (end_of_buf) begin
			emit_record(recs, rcp_pkg::KIND_BUFEND, 3'd0, 5'd0, 64'd0);
			reset_parse();
		end
		if (recs.size() > 0)
			recs[recs.size() - 1].last = 1'b1;
		foreach (recs[i])
			pending_records.insert(pending_records.size(), recs[i]);
	endtask

	// Offers one byte and returns at the rising edge where it is taken.
	task automatic send_byte(input logic [7:0] b, input logic end_of_buf);
		if (!no_idle && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= end_of_buf;
		do @(negedge clk); while (!s_tready);
		predict_byte(b, end_of_buf);
		@(posedge clk);
	endtask

	task automatic send_buffer(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Sender stops until every expected record is out and the block has settled.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Appends one packet: header, random body, and the pad count, if given, as its final byte.
	task automatic add_packet(ref logic [7:0] buf_q[$], input logic [1:0] ver, input logic pad,
			input logic [4:0] rc, input logic [7:0] ptype, input logic [15:0] lw,
			input int pad_count);
		int total;
		total = (int'(lw) + 1) * 4;
		buf_q.insert(buf_q.size(), {ver, pad, rc});
		buf_q.insert(buf_q.size(), ptype);
		buf_q.insert(buf_q.size(), lw[15:8]);
		buf_q.insert(buf_q.size(), lw[7:0]);
		for (int i = 4; i < total; i++)
			buf_q.insert(buf_q.size(), (i == total - 1 && pad_count >= 0) ? pad_count[7:0]
				: 8'($urandom()));
	endtask

	task automatic test_well_formed_types();
		logic [7:0] q[$];
		q = {};
		// Feedback with padding and nothing to pad, an unknown type with the padding bit,
		// and a padded application packet.
		add_packet(q, 2'd2, 1'b1, 5'd0, rcp_pkg::T_PSFB, 16'd2, -1);
		add_packet(q, 2'd1, 1'b1, 5'd3, 8'd100, 16'd0, -1);
		add_packet(q, 2'd2, 1'b1, 5'd0, T_APP, 16'd1, 4);
		send_buffer(q);
		wait_for_drain();
	endtask

	task automatic test_malformed_and_cut();
		logic [7:0] q[$];
		// Short sender report; the bytes after its header must be ignored.
		q = {};
		add_packet(q, 2'd2, 1'b0, 5'd0, rcp_pkg::T_SR, 16'd1, -1);
		send_buffer(q);
		// Short packet whose buffer ends on the header byte.
		q = {8'h81, rcp_pkg::T_RR, 8'h00, 8'h02};
		send_buffer(q);
		// Zero pad count, then a pad count larger than the payload.
		q = {};
		add_packet(q, 2'd2, 1'b1, 5'd0, T_BYE, 16'd1, 0);
		send_buffer(q);
		q = {};
		add_packet(q, 2'd2, 1'b1, 5'd0, T_BYE, 16'd1, 255);
		send_buffer(q);
		// Packet cut by the buffer end, at the largest length.
		q = {8'h1F, rcp_pkg::T_RR, 8'hFF, 8'hFF, 8'h12, 8'h34};
		send_buffer(q);
		// Buffer ending inside a header, and a single-byte buffer.
		q = {8'h80, 8'hC8};
		send_buffer(q);
		q = {8'h00};
		send_buffer(q);
		wait_for_drain();
	endtask

	// Random compound buffers: mostly valid packets with random content, some broken.
	task automatic random_buffers(input int byte_budget);
		logic [7:0] q[$];
		int sent;
		int npkt;
		int sel;
		logic [7:0] ptype;
		logic [4:0] rc;
		int pstart;
		int minw;
		int lw;
		int plen;
		logic pad;
		int padc;
		sent = 0;
		while (sent < byte_budget) begin
			q = {};
			npkt = $urandom_range(1, 3);
			for (int p = 0; p < npkt; p++) begin
				sel = $urandom_range(0, 7);
				ptype = (sel == 7) ? 8'($urandom()) : 8'(200 + sel);
				rc = (ptype == rcp_pkg::T_SR || ptype == rcp_pkg::T_RR)
					? 5'($urandom_range(0, 1)) : 5'($urandom());
				if (ptype == rcp_pkg::T_SR) pstart = 28 + 24 * int'(rc);
				else if (ptype == rcp_pkg::T_RR) pstart = 8 + 24 * int'(rc);
				else if (ptype == rcp_pkg::T_RTPFB || ptype == rcp_pkg::T_PSFB) pstart = 12;
				else pstart = 4;
				minw = pstart / 4 - 1;
				lw = minw + $urandom_range(0, 3);
				if ($urandom_range(0, 9) == 0 && minw > 0)
					lw = $urandom_range(0, minw - 1);
				plen = (lw + 1) * 4 - pstart;
				pad = $urandom_range(0, 2) == 0;
				padc = -1;
				if (pad && plen > 0)
					padc = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : $urandom_range(1, plen);
				add_packet(q, 2'($urandom()), pad, rc, ptype, 16'(lw), padc);
			end
			// Some buffers are cut short or carry a flipped byte.
			sel = $urandom_range(0, 9);
			if (sel == 0)
				q = q[0:$urandom_range(0, q.size() - 1)];
			else if (sel == 1)
				q[$urandom_range(0, q.size() - 1)] = 8'($urandom());
			send_buffer(q);
			sent += q.size();
		end
	endtask

	// The receiver holds off while a sender report with a report block keeps coming,
	// then the sender waits for a full drain.
	task automatic test_backpressure();
		logic [7:0] q[$];
		q = {};
		add_packet(q, 2'd2, 1'b0, 5'd1, rcp_pkg::T_SR, 16'd12, -1);
		hold_cycles = 300;
		send_buffer(q);
		wait_for_drain();
	endtask

	// Random buffers with no idling on either side.
	task automatic test_full_rate();
		no_idle = 1'b1;
		random_buffers(20);
		wait_for_drain();
	endtask

	initial begin
		reset_parse();
		byte_history = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_well_formed_types();
		test_malformed_and_cut();
		test_backpressure();
		test_full_rate();
		if (error_count == 0) begin
			$display("rtcp_compound_parser_tb: clean");
		end else begin
			$display("rtcp_compound_parser_tb: errors");
		end
		$finish;
	end

endmodule
